FILE: hw/rtl/ghp_pkg.sv
package ghp_pkg;

    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 8;
    localparam int GEN_W    = 16;
    localparam int USED_W   = 9;

    localparam int DEF_SLOTS    = 256;
    localparam int DEF_GEN_BITS = 16;

    localparam logic [FUNC_W-1:0] FN_ALLOC  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_FREE   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STALE = 2'd2;

endpackage

FILE: hw/rtl/ghp_ram.sv
module ghp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/ghp_gen_unit.sv
module ghp_gen_unit
    import ghp_pkg::*;
#(
    parameter int GEN_BITS = DEF_GEN_BITS
) (
    input  logic [GEN_BITS-1:0] i_gen_cur,
    input  logic [GEN_BITS-1:0] i_gen_ref,
    output logic [GEN_BITS-1:0] o_gen_next,
    output logic                o_match
);

    assign o_gen_next = i_gen_cur + GEN_BITS'(1);
    assign o_match    = (i_gen_cur == i_gen_ref);

endmodule

FILE: hw/rtl/generational_handle_pool_core.sv
// Handle pool: hands out handles (slot index, generation), frees and checks them.
//
// Request channel i_valid/o_ready carries i_func (allocate, free, lookup),
// i_slot_index and i_slot_generation. Result channel o_valid/i_ready carries
// o_status, o_handle_index, o_handle_generation and o_used_slots.
//
// One request at a time. After acceptance the slot word is read from a single
// read port RAM with registered output and checked through one generation
// increment/compare unit; an allocate or a successful free writes the updated
// word back. The result is registered through the read and update states
// (the update state is skipped for a full pool or an out-of-range index).
// o_ready returns the cycle after the result is taken; while the result
// waits, the block holds it and takes no new request.
//
// Reset empties the free list and clears the high-water count. Slots at or
// above the high-water count read as dead with generation zero, so the RAM
// needs no clearing pass and the block is ready right after reset.
module generational_handle_pool_core
    import ghp_pkg::*;
#(
    parameter int SLOTS    = DEF_SLOTS,
    parameter int GEN_BITS = DEF_GEN_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [IDX_W-1:0]    i_slot_index,
    input  logic [GEN_W-1:0]    i_slot_generation,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [IDX_W-1:0]    o_handle_index,
    output logic [GEN_W-1:0]    o_handle_generation,
    output logic [USED_W-1:0]   o_used_slots
);

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int HW_W    = $clog2(SLOTS + 1);
    localparam int WORD_W  = GEN_BITS + SLOT_W + 2;
    localparam int LIVE_B  = GEN_BITS;
    localparam int LINK_L  = GEN_BITS + 1;
    localparam int LINKV_B = GEN_BITS + SLOT_W + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EVAL = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [SLOT_W-1:0]   r_head;
    logic                r_head_valid;
    logic [HW_W-1:0]     r_high_water;

    logic [FUNC_W-1:0]   r_func;
    logic [SLOT_W-1:0]   r_slot;
    logic [IDX_W-1:0]    r_out_idx;
    logic [GEN_BITS-1:0] r_gen_in;
    logic                r_fresh;
    logic                r_from_head;
    logic                r_full;
    logic                r_oob;

    logic [STATUS_W-1:0] r_status;
    logic [IDX_W-1:0]    r_hidx;
    logic [GEN_W-1:0]    r_hgen;
    logic [USED_W-1:0]   r_used;

    logic                in_alloc;
    logic [SLOT_W-1:0]   in_slot;
    logic                in_full;
    logic                in_oob;
    logic                accept;

    logic [WORD_W-1:0]   ram_rdata;
    logic [WORD_W-1:0]   ram_wdata;
    logic                ram_we;
    logic                ram_re;

    logic                cur_live;
    logic [GEN_BITS-1:0] cur_gen;
    logic [GEN_BITS-1:0] gen_next;
    logic                gen_match;
    logic                handle_ok;
    logic                is_alloc;
    logic                is_free;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    assign in_alloc = (i_func == FN_ALLOC);
    assign in_slot  = in_alloc ? (r_head_valid ? r_head : r_high_water[SLOT_W-1:0])
                               : SLOT_W'(i_slot_index);
    assign in_full  = in_alloc && !r_head_valid && (r_high_water == HW_W'(SLOTS));
    assign in_oob   = !in_alloc && (int'(i_slot_index) >= SLOTS);

    assign is_alloc = (r_func == FN_ALLOC);
    assign is_free  = (r_func == FN_FREE);

    assign cur_live  = r_fresh ? 1'b0 : ram_rdata[LIVE_B];
    assign cur_gen   = r_fresh ? '0 : ram_rdata[GEN_BITS-1:0];
    assign handle_ok = cur_live && gen_match;

    ghp_gen_unit #(
        .GEN_BITS (GEN_BITS)
    ) u_gen_unit (
        .i_gen_cur  (cur_gen),
        .i_gen_ref  (r_gen_in),
        .o_gen_next (gen_next),
        .o_match    (gen_match)
    );

    assign ram_re = (r_state == S_READ);
    assign ram_we = (r_state == S_EVAL) && (is_alloc || (is_free && handle_ok));

    always_comb begin
        if (is_alloc) begin
            ram_wdata = {ram_rdata[LINKV_B], ram_rdata[LINK_L +: SLOT_W], 1'b1, gen_next};
        end else begin
            ram_wdata = {r_head_valid, r_head, 1'b0, gen_next};
        end
    end

    ghp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = (r_full || r_oob) ? S_RESP : S_EVAL;
            end
            S_EVAL: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func      <= i_func;
            r_slot      <= in_slot;
            r_out_idx   <= in_alloc ? IDX_W'(in_slot) : i_slot_index;
            r_gen_in    <= GEN_BITS'(i_slot_generation);
            r_fresh     <= (HW_W'(in_slot) >= r_high_water);
            r_from_head <= in_alloc && r_head_valid;
            r_full      <= in_full;
            r_oob       <= in_oob;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_head       <= '0;
            r_high_water <= '0;
        end else if (r_state == S_EVAL) begin
            if (is_alloc) begin
                if (r_from_head) begin
                    r_head_valid <= ram_rdata[LINKV_B];
                    r_head       <= ram_rdata[LINK_L +: SLOT_W];
                end else begin
                    r_high_water <= r_high_water + HW_W'(1);
                end
            end else if (is_free && handle_ok) begin
                r_head_valid <= 1'b1;
                r_head       <= r_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_used <= USED_W'(r_high_water);
            r_hgen <= '0;
            if (r_full) begin
                r_status <= ST_FULL;
                r_hidx   <= '0;
            end else begin
                r_status <= ST_STALE;
                r_hidx   <= r_out_idx;
            end
        end else if (r_state == S_EVAL) begin
            r_hidx <= r_out_idx;
            if (is_alloc) begin
                r_status <= ST_OK;
                r_hgen   <= GEN_W'(gen_next);
                r_used   <= r_from_head ? USED_W'(r_high_water)
                                        : USED_W'(r_high_water + HW_W'(1));
            end else begin
                r_status <= handle_ok ? ST_OK : ST_STALE;
                r_hgen   <= (is_free && handle_ok) ? GEN_W'(gen_next) : GEN_W'(cur_gen);
                r_used   <= USED_W'(r_high_water);
            end
        end
    end

    assign o_valid             = (r_state == S_RESP);
    assign o_status            = r_status;
    assign o_handle_index      = r_hidx;
    assign o_handle_generation = r_hgen;
    assign o_used_slots        = r_used;

    a_hw_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_high_water <= HW_W'(SLOTS))
        else $error("high-water count above pool size");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("request taken while result pending");

    a_free_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && is_free && handle_ok) |=> (r_head_valid && r_head == $past(r_slot)))
        else $error("free did not push slot onto list");

    a_write_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_EVAL))
        else $error("slot write outside update cycle");

    a_full_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (!r_head_valid && r_high_water == HW_W'(SLOTS)))
        else $error("full reported with free slots left");

endmodule

FILE: bench/generational_handle_pool_core_tb.sv
`timescale 1ns / 1ps

module generational_handle_pool_core_tb;
    import ghp_pkg::*;

    localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;
    localparam logic [USED_W-1:0] LIST_END = USED_W'(DEF_SLOTS);
    localparam int IDLE_LIMIT = 1000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    index;
        logic [GEN_W-1:0]    generation;
        logic [USED_W-1:0]   used;
    } t_pool_result;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [GEN_W-1:0] gen;
    } t_slot_handle;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [FUNC_W-1:0]   i_func = FN_ALLOC;
    logic [IDX_W-1:0]    i_slot_index = '0;
    logic [GEN_W-1:0]    i_slot_generation = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [IDX_W-1:0]    o_handle_index;
    logic [GEN_W-1:0]    o_handle_generation;
    logic [USED_W-1:0]   o_used_slots;

    bit                slot_live [DEF_SLOTS];
    logic [GEN_W-1:0]  slot_gen  [DEF_SLOTS];
    logic [USED_W-1:0] slot_next [DEF_SLOTS];
    bit                list_head_valid;
    logic [IDX_W-1:0]  list_head;
    logic [USED_W-1:0] high_water_cnt;

    t_pool_result pending_results[$];
    t_slot_handle live_handles[$];
    t_slot_handle retired_handles[$];

    int mismatch_count = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit quiet = 1'b0;

    generational_handle_pool_core dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_func              (i_func),
        .i_slot_index        (i_slot_index),
        .i_slot_generation   (i_slot_generation),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_status            (o_status),
        .o_handle_index      (o_handle_index),
        .o_handle_generation (o_handle_generation),
        .o_used_slots        (o_used_slots)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic t_pool_result predict_pool_result(logic [FUNC_W-1:0] f,
                                                         logic [IDX_W-1:0] idx,
                                                         logic [GEN_W-1:0] g);
        t_pool_result r;
        logic [IDX_W-1:0] slot;
        bit granted;
        r = '0;
        if (f == FN_ALLOC) begin
            granted = 1'b1;
            slot = '0;
            if (list_head_valid) begin
                slot = list_head;
                list_head_valid = 1'b0;
                if (slot_next[slot] < LIST_END) begin
                    list_head = slot_next[slot][IDX_W-1:0];
                    list_head_valid = 1'b1;
                end
            end else if (high_water_cnt < LIST_END) begin
                slot = high_water_cnt[IDX_W-1:0];
                high_water_cnt = high_water_cnt + 1'b1;
            end else begin
                granted = 1'b0;
            end
            if (granted) begin
                slot_gen[slot] = slot_gen[slot] + 1'b1;
                slot_live[slot] = 1'b1;
                r.status = ST_OK;
                r.index = slot;
                r.generation = slot_gen[slot];
            end else begin
                r.status = ST_FULL;
            end
        end else if (f == FN_FREE) begin
            if (slot_live[idx] && slot_gen[idx] == g) begin
                slot_gen[idx] = slot_gen[idx] + 1'b1;
                slot_live[idx] = 1'b0;
                slot_next[idx] = list_head_valid ? {1'b0, list_head} : LIST_END;
                list_head = idx;
                list_head_valid = 1'b1;
                r.status = ST_OK;
            end else begin
                r.status = ST_STALE;
            end
            r.index = idx;
            r.generation = slot_gen[idx];
        end else begin
            r.status = (slot_live[idx] && slot_gen[idx] == g) ? ST_OK : ST_STALE;
            r.index = idx;
            r.generation = slot_gen[idx];
        end
        r.used = high_water_cnt;
        return r;
    endfunction

    task automatic send_request(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] idx,
                                input logic [GEN_W-1:0] g);
        int gap;
        t_pool_result r;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= f;
        i_slot_index <= idx;
        i_slot_generation <= g;
        do @(posedge i_clk); while (!o_ready);
        r = predict_pool_result(f, idx, g);
        pending_results.push_back(r);
        if (r.status == ST_OK && f == FN_ALLOC)
            live_handles.push_back('{idx: r.index, gen: r.generation});
        if (r.status == ST_OK && f == FN_FREE) begin
            foreach (live_handles[i]) begin
                if (live_handles[i].idx == idx) begin
                    live_handles.delete(i);
                    break;
                end
            end
            retired_handles.push_back('{idx: idx, gen: g});
            if (retired_handles.size() > 64) void'(retired_handles.pop_front());
        end
    endtask

    task automatic pause_until_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_after_reset();
        send_request(FN_LOOKUP, 8'd0, 16'd0);
        send_request(FN_LOOKUP, 8'd255, 16'hFFFF);
        send_request(FN_FREE, 8'd7, 16'd0);
        send_request(FN_SPARE, 8'd128, 16'd0);
    endtask

    task automatic test_basic_ops();
        repeat (3) send_request(FN_ALLOC, 8'hFF, 16'hFFFF);
        send_request(FN_LOOKUP, 8'd1, 16'd1);
        send_request(FN_LOOKUP, 8'd1, 16'd0);
        send_request(FN_LOOKUP, 8'd1, 16'h8001);
        send_request(FN_SPARE, 8'd2, 16'd1);
        send_request(FN_FREE, 8'd1, 16'd1);
        send_request(FN_FREE, 8'd1, 16'd1);
        send_request(FN_LOOKUP, 8'd1, 16'd2);
        send_request(FN_FREE, 8'd0, 16'd1);
        repeat (3) send_request(FN_ALLOC, 8'd0, 16'd0);
        send_request(FN_FREE, 8'd2, 16'd5);
        send_request(FN_FREE, 8'd2, 16'd1);
        send_request(FN_SPARE, 8'd2, 16'd1);
    endtask

    task automatic test_random_traffic(input int count, input int alloc_pct);
        int r;
        int n;
        t_slot_handle h;
        logic [IDX_W-1:0] idx;
        logic [FUNC_W-1:0] f;
        repeat (count) begin
            r = $urandom_range(0, 99);
            n = live_handles.size();
            if (r < alloc_pct) begin
                send_request(FN_ALLOC, IDX_W'($urandom), GEN_W'($urandom));
            end else if (r < alloc_pct + 25 && n > 0) begin
                h = live_handles[$urandom_range(0, n - 1)];
                send_request(FN_FREE, h.idx, h.gen);
            end else if (r < alloc_pct + 38 && n > 0) begin
                h = live_handles[$urandom_range(0, n - 1)];
                send_request($urandom_range(0, 3) == 0 ? FN_SPARE : FN_LOOKUP, h.idx, h.gen);
            end else if (r < alloc_pct + 48 && retired_handles.size() > 0) begin
                h = retired_handles[$urandom_range(0, retired_handles.size() - 1)];
                send_request($urandom_range(0, 1) ? FN_FREE : FN_LOOKUP, h.idx, h.gen);
            end else begin
                idx = IDX_W'($urandom);
                case ($urandom_range(0, 2))
                    0: f = FN_FREE;
                    1: f = FN_LOOKUP;
                    default: f = FN_SPARE;
                endcase
                send_request(f, idx, $urandom_range(0, 1) ? slot_gen[idx] : GEN_W'($urandom));
            end
        end
    endtask

    task automatic test_pool_full();
        t_slot_handle h;
        pause_until_drained();
        while (list_head_valid || high_water_cnt < LIST_END)
            send_request(FN_ALLOC, IDX_W'($urandom), GEN_W'($urandom));
        repeat (3) send_request(FN_ALLOC, IDX_W'($urandom), GEN_W'($urandom));
        h = live_handles[$urandom_range(0, live_handles.size() - 1)];
        send_request(FN_FREE, h.idx, h.gen);
        send_request(FN_LOOKUP, h.idx, h.gen);
        send_request(FN_ALLOC, 8'd0, 16'd0);
        send_request(FN_ALLOC, 8'd0, 16'd0);
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin : check_results
        t_pool_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request pending: status %0d index %0d",
                       o_status, o_handle_index);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatch_count++;
                end
                if (o_handle_index !== want.index) begin
                    $error("handle_index: expected %0d, got %0d", want.index, o_handle_index);
                    mismatch_count++;
                end
                if (o_handle_generation !== want.generation) begin
                    $error("handle_generation: expected %0d, got %0d",
                           want.generation, o_handle_generation);
                    mismatch_count++;
                end
                if (o_used_slots !== want.used) begin
                    $error("used_slots: expected %0d, got %0d", want.used, o_used_slots);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("CHECKS FAILED");
                    $finish;
                end
            end
        end
    end

    initial begin
        foreach (slot_live[i]) begin
            slot_live[i] = 1'b0;
            slot_gen[i] = '0;
            slot_next[i] = '0;
        end
        list_head_valid = 1'b0;
        list_head = '0;
        high_water_cnt = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_basic_ops();
        test_random_traffic(500, 50);
        test_pool_full();
        test_random_traffic(400, 30);
        quiet = 1'b1;
        test_random_traffic(60, 40);
        quiet = 1'b0;
        test_random_traffic(240, 40);

        pause_until_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
